// ===== hw/rtl/bpfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpfa_pkg: shared types and constants for the page-frame allocator
// Command and result beat layouts, mode and status codes, and the word-level
// scan result passed from the word unit to the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfa_pkg;

  localparam int NUM_PAGES_DEF = 4096;

  // The bitmap is held as 16-bit words, one word per RAM entry
  localparam int WORD_W = 16;
  localparam int BIT_W  = 4;
  localparam int CNT_W  = 5;   // holds 0..WORD_W

  localparam int MODE_W = 3;
  localparam int PAGE_W = 20;
  localparam int END_W  = 21;
  localparam int LEN_W  = 13;
  localparam int IDX_W  = 12;

  localparam logic [MODE_W-1:0] MODE_ALLOC_ONE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC_RUN  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FREE_PAGE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RANGE_FREE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RANGE_USED = 3'd4;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_OOM = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PAGE_W-1:0] page;
    logic [END_W-1:0]  range_end;
    logic [LEN_W-1:0]  run_length;
  } bpfa_cmd_t;

  typedef struct packed {
    logic             status;
    logic [IDX_W-1:0] page_index;
  } bpfa_rsp_t;

  typedef struct packed {
    logic             all_free;  // every page in the word is free
    logic             cont_hit;  // run carried in from lower words completes here
    logic             win_hit;   // a run fits entirely inside this word
    logic [BIT_W-1:0] win_pos;   // lowest bit of that run
    logic [CNT_W-1:0] suffix;    // free pages at the top of the word
  } bpfa_scan_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bpfa_ram.sv =====
// ----------------------------------------------------------------------------
// bpfa_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfa_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bpfa_word_unit.sv =====
// ----------------------------------------------------------------------------
// bpfa_word_unit: per-word search and update unit
// Looks at one 16-page bitmap word: free-run search for allocation and the
// masked set/clear used by range writes.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfa_word_unit (
  input  logic [bpfa_pkg::WORD_W-1:0] word,
  input  logic [bpfa_pkg::LEN_W-1:0]  len,
  input  logic [bpfa_pkg::LEN_W-1:0]  cnt,
  input  logic [bpfa_pkg::BIT_W-1:0]  lo,
  input  logic [bpfa_pkg::BIT_W-1:0]  hi,
  input  logic                        set_val,
  output bpfa_pkg::bpfa_scan_t        scan,
  output logic [bpfa_pkg::WORD_W-1:0] wdata
);

  import bpfa_pkg::*;

  logic [CNT_W-1:0]  prefix;
  logic [CNT_W-1:0]  suffix;
  logic [WORD_W-1:0] len_mask;
  logic [WORD_W-1:0] range_mask;
  logic              win_hit;
  logic [BIT_W-1:0]  win_pos;
  logic [LEN_W:0]    cont_sum;

  // free pages from bit 0 up to the first used one
  always_comb begin
    prefix = CNT_W'(WORD_W);
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (word[j]) prefix = CNT_W'(j);
    end
  end

  // free pages from the top down to the last used one
  always_comb begin
    suffix = CNT_W'(WORD_W);
    for (int j = 0; j < WORD_W; j++) begin
      if (word[j]) suffix = CNT_W'(WORD_W - 1 - j);
    end
  end

  assign len_mask = (len >= LEN_W'(WORD_W)) ? '1 :
                    ((WORD_W'(1) << len[BIT_W-1:0]) - WORD_W'(1));

  // lowest window of len free pages lying wholly inside the word
  always_comb begin
    win_hit = 1'b0;
    win_pos = '0;
    for (int s = WORD_W - 1; s >= 0; s--) begin
      if ((32'(s) + 32'(len) <= 32'(WORD_W)) && (((word >> s) & len_mask) == '0)) begin
        win_hit = 1'b1;
        win_pos = BIT_W'(s);
      end
    end
  end

  assign cont_sum = {1'b0, cnt} + (LEN_W + 1)'(prefix);

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      range_mask[j] = (BIT_W'(j) >= lo) && (BIT_W'(j) <= hi);
    end
  end

  assign wdata = set_val ? (word | range_mask) : (word & ~range_mask);

  assign scan.all_free = (word == '0);
  assign scan.cont_hit = (cnt != '0) && (cont_sum >= {1'b0, len});
  assign scan.win_hit  = win_hit;
  assign scan.win_pos  = win_pos;
  assign scan.suffix   = suffix;

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_page_frame_allocator_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_core: first-fit bitmap page-frame allocator
// One used bit per page kept in a 16-bit-wide RAM, walked one word per cycle
// by a small sequencer around a shared word search/update unit.
// ----------------------------------------------------------------------------
// Usage: after rst the block runs a clearing pass over every bitmap word that
// marks every page used; busy is high during it. A command beat is taken when
// start is high and busy is low; the block then stays busy until its single
// result beat, which appears on result for exactly one cycle with done high.
// There is no backpressure on results: the receiver must take the beat in that
// cycle. Allocate one / allocate a run scan the bitmap one word per cycle from
// page 0 through the single RAM read port, then on success write the run back
// at one word per cycle. Free page and the range commands read, modify and
// write back each word spanned. Empty ranges, zero run length and unknown
// modes answer without touching the bitmap.
// Out of memory gives status 1 with page_index 0; the map is then unchanged.
`default_nettype none

module bitmap_page_frame_allocator_core #(
  parameter int NUM_PAGES = bpfa_pkg::NUM_PAGES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  bpfa_pkg::bpfa_cmd_t cmd,
  output logic                done,
  output bpfa_pkg::bpfa_rsp_t result
);

  import bpfa_pkg::*;

  localparam int WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
  localparam int AW    = $clog2(WORDS);
  localparam int POS_W = AW + BIT_W;   // page position
  localparam int EP_W  = POS_W + 1;    // exclusive end position
  localparam logic [AW:0]      LAST_WORD = (AW + 1)'(WORDS - 1);
  localparam logic [END_W-1:0] NUM_END   = END_W'(NUM_PAGES);

  typedef enum logic [2:0] {
    S_CLEAR,   // reset sweep, all words to used
    S_IDLE,
    S_SCAN,    // first-fit search, one word per cycle
    S_RINIT,   // load the range write pointer
    S_RANGE,   // read-modify-write over the range
    S_RESP     // result beat
  } state_t;

  state_t           state;
  logic [AW:0]      ptr;        // next word to read (or clear)
  logic             dv;         // rdata holds word da
  logic [AW-1:0]    da;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] cnt;        // free run carried from lower words
  logic [POS_W-1:0] run_start;
  logic [POS_W-1:0] first;
  logic [EP_W-1:0]  last_excl;
  logic             set_val;
  bpfa_rsp_t        res;

  // RAM and word unit
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] unit_wdata;
  bpfa_scan_t        scan;
  logic [BIT_W-1:0]  lo;
  logic [BIT_W-1:0]  hi;

  logic [EP_W-1:0]   end_m1;
  logic [AW-1:0]     first_word;
  logic [AW-1:0]     last_word;
  logic [AW:0]       stop_word;
  logic              rd_go;
  logic [POS_W-1:0]  base;
  logic [POS_W-1:0]  found_start;
  logic [EP_W-1:0]   found_end;
  logic [POS_W-1:0]  suffix_start;

  // command decode helpers
  logic [END_W-1:0]  end_c;
  logic              page_ok;
  logic              range_ok;

  assign end_m1     = last_excl - EP_W'(1);
  assign first_word = first[POS_W-1:BIT_W];
  assign last_word  = end_m1[POS_W-1:BIT_W];
  assign stop_word  = (state == S_SCAN) ? LAST_WORD : {1'b0, last_word};
  assign rd_go      = ((state == S_SCAN) || (state == S_RANGE)) && (ptr <= stop_word);

  assign base         = {da, BIT_W'(0)};
  assign found_start  = scan.cont_hit ? run_start : {da, scan.win_pos};
  assign found_end    = EP_W'(found_start) + EP_W'(len);
  assign suffix_start = base + POS_W'(CNT_W'(WORD_W) - scan.suffix);

  // edge words of a range only touch part of the word
  assign lo = (da == first_word) ? first[BIT_W-1:0] : '0;
  assign hi = (da == last_word) ? end_m1[BIT_W-1:0] : '1;

  assign end_c    = (cmd.range_end > NUM_END) ? NUM_END : cmd.range_end;
  assign page_ok  = ({1'b0, cmd.page} < NUM_END);
  assign range_ok = ({1'b0, cmd.page} < end_c);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = da;
    ram_wdata = unit_wdata;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = ptr[AW-1:0];
      ram_wdata = '1;
    end else if (state == S_RANGE) begin
      ram_we = dv;
    end
  end

  bpfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr[AW-1:0]),
    .rdata (rdata)
  );

  bpfa_word_unit u_word (
    .word    (rdata),
    .len     (len),
    .cnt     (cnt),
    .lo      (lo),
    .hi      (hi),
    .set_val (set_val),
    .scan    (scan),
    .wdata   (unit_wdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ptr   <= '0;
      dv    <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          ptr <= ptr + (AW + 1)'(1);
          if (ptr == LAST_WORD) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          dv        <= 1'b0;
          ptr       <= '0;
          cnt       <= '0;
          first     <= POS_W'(cmd.page);
          last_excl <= EP_W'(end_c);
          res       <= '{status: ST_OK, page_index: '0};
          if (start) begin
            unique case (cmd.mode) inside
              MODE_ALLOC_ONE: begin
                len   <= LEN_W'(1);
                state <= S_SCAN;
              end
              MODE_ALLOC_RUN: begin
                len <= cmd.run_length;
                if (cmd.run_length == '0) begin
                  res   <= '{status: ST_OOM, page_index: '0};
                  state <= S_RESP;
                end else begin
                  state <= S_SCAN;
                end
              end
              MODE_FREE_PAGE: begin
                set_val   <= 1'b0;
                last_excl <= EP_W'(cmd.page) + EP_W'(1);
                state     <= page_ok ? S_RINIT : S_RESP;
              end
              MODE_RANGE_FREE, MODE_RANGE_USED: begin
                set_val <= (cmd.mode == MODE_RANGE_USED);
                state   <= range_ok ? S_RINIT : S_RESP;
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end

        S_SCAN: begin
          dv <= rd_go;
          da <= ptr[AW-1:0];
          if (rd_go) ptr <= ptr + (AW + 1)'(1);
          if (dv) begin
            if (scan.cont_hit || scan.win_hit) begin
              // mark the run used, then answer
              first     <= found_start;
              last_excl <= found_end;
              set_val   <= 1'b1;
              res       <= '{status: ST_OK, page_index: IDX_W'(found_start)};
              state     <= S_RINIT;
            end else if (da == LAST_WORD[AW-1:0]) begin
              res   <= '{status: ST_OOM, page_index: '0};
              state <= S_RESP;
            end else if (scan.all_free) begin
              if (cnt == '0) run_start <= base;
              cnt <= cnt + LEN_W'(WORD_W);
            end else begin
              cnt       <= LEN_W'(scan.suffix);
              run_start <= suffix_start;
            end
          end
        end

        S_RINIT: begin
          dv    <= 1'b0;
          ptr   <= {1'b0, first_word};
          state <= S_RANGE;
        end

        S_RANGE: begin
          // word da is written back this cycle while da+1 is read
          dv <= rd_go;
          da <= ptr[AW-1:0];
          if (rd_go) ptr <= ptr + (AW + 1)'(1);
          if (dv && (da == last_word)) begin
            state <= S_RESP;
          end
        end

        S_RESP: begin
          state <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy   = (state != S_IDLE);
  assign done   = (state == S_RESP);
  assign result = res;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not make the block busy");

  // quick answers come straight from the accept cycle
  a_done_after_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result beat without a command in progress");

  a_write_window : assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_RANGE))
    else $error("bitmap written outside clear or range phase");

  a_oom_index : assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_OOM) |-> (result.page_index == '0))
    else $error("out-of-memory beat carries a nonzero page index");

endmodule

`default_nettype wire
